FILE: sv/rrf_pkg.sv
// ---------------------------------------------------------------------------
// rrf_pkg: shared types and constants of the raster rectangle fill engine
// Holds the command codes, register indexes, field widths and the struct
// types that pass between the front, the queue and the back.
// ---------------------------------------------------------------------------
package rrf_pkg;

  localparam int unsigned CoordW    = 9;
  localparam int unsigned ColorW    = 8;
  localparam int unsigned FuncW     = 3;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned DefMaxDim = 256;
  localparam int unsigned DefQDepth = 2;

  localparam logic [FuncW-1:0] FUNC_CLEAR = 3'd0;
  localparam logic [FuncW-1:0] FUNC_PLOT  = 3'd1;
  localparam logic [FuncW-1:0] FUNC_VLINE = 3'd2;
  localparam logic [FuncW-1:0] FUNC_HLINE = 3'd3;
  localparam logic [FuncW-1:0] FUNC_RECT  = 3'd4;
  localparam logic [FuncW-1:0] FUNC_READ  = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_CANVAS_WIDTH  = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_CANVAS_HEIGHT = 4'd1;

  localparam logic [CoordW-1:0] CANVAS_RESET = 9'd1;
  localparam logic [ColorW-1:0] CLEAR_COLOR  = 8'h4F;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FILL,
    KIND_READ
  } kind_e;

  // control part of one classified item
  typedef struct packed {
    kind_e             kind;
    logic              err;
    logic [ColorW-1:0] color;
  } rrf_ctl_t;

  // back status seen by the top level
  typedef struct packed {
    logic idle;
    logic writing;
  } rrf_back_st_t;

endpackage

FILE: sv/rrf_if.sv
// ---------------------------------------------------------------------------
// rrf_if: channel interfaces of the raster rectangle fill engine
// Command channel, result channel and configuration write channel, each
// with valid, ready and payload.
// ---------------------------------------------------------------------------
interface rrf_cmd_if import rrf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [CoordW-1:0] col_start;
  logic [CoordW-1:0] col_end;
  logic [CoordW-1:0] row_start;
  logic [CoordW-1:0] row_end;
  logic [ColorW-1:0] color;

  modport source (output valid, func, col_start, col_end, row_start, row_end, color,
                  input ready);
  modport sink   (input valid, func, col_start, col_end, row_start, row_end, color,
                  output ready);
endinterface

interface rrf_res_if import rrf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] read_color;
  logic              range_error;

  modport source (output valid, read_color, range_error, input ready);
  modport sink   (input valid, read_color, range_error, output ready);
endinterface

interface rrf_cfg_if import rrf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/raster_rect_fill_engine_core.sv
// Path: an accepted command waits in the queue; the back end takes it when
// idle, draws or reads, and hands the result to an output register.
// A new item is taken only once the last is done; the single frame store
// port takes one pixel write per cycle, and a 2-entry queue buffers commands.
// Reset: control and queue cleared, canvas 1 by 1; the frame store is not
// cleared and a pixel in it is defined only once written.
// ---------------------------------------------------------------------------
// raster_rect_fill_engine_core: raster drawing engine top level
// Front end classifies commands, a short queue decouples it from the back
// end that fills boxes and reads pixels in the frame store.
// ---------------------------------------------------------------------------
module raster_rect_fill_engine_core import rrf_pkg::*; #(
  parameter int unsigned MAX_DIM = DefMaxDim
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rrf_cmd_if.sink   cmd_i,
  rrf_cfg_if.sink   cfg_i,
  rrf_res_if.source res_o
);

  localparam int unsigned ColW  = $clog2(MAX_DIM);
  localparam int unsigned AddrW = $clog2(MAX_DIM * MAX_DIM);
  localparam int unsigned CtlW  = $bits(rrf_ctl_t);
  localparam int unsigned EntW  = CtlW + 4 * ColW + AddrW;

  logic             push, pop, q_full, q_valid;
  rrf_ctl_t         f_ctl, b_ctl;
  logic [ColW-1:0]  f_c0, f_c1, f_r0, f_r1;
  logic [ColW-1:0]  b_c0, b_c1, b_r0, b_r1;
  logic [AddrW-1:0] f_addr, b_addr;
  logic [EntW-1:0]  q_in, q_out;
  rrf_back_st_t     back_st;

  rrf_front #(
    .MaxDim (MAX_DIM)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .push_o   (push),
    .ctl_o    (f_ctl),
    .c0_o     (f_c0),
    .c1_o     (f_c1),
    .r0_o     (f_r0),
    .r1_o     (f_r1),
    .addr_o   (f_addr)
  );

  assign q_in = {f_ctl, f_c0, f_c1, f_r0, f_r1, f_addr};

  rrf_queue #(
    .Width (EntW),
    .Depth (DefQDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign {b_ctl, b_c0, b_c1, b_r0, b_r1, b_addr} = q_out;

  rrf_back #(
    .MaxDim (MAX_DIM)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .ctl_i     (b_ctl),
    .c0_i      (b_c0),
    .c1_i      (b_c1),
    .r0_i      (b_r0),
    .r1_i      (b_r1),
    .addr_i    (b_addr),
    .pop_o     (pop),
    .st_o      (back_st),
    .res_o     (res_o)
  );

  // no new item is taken while a box is still being drawn
  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> back_st.idle && !back_st.writing)
    else $error("queue popped while back end busy");

  // a result never appears straight out of a fill sweep
  a_no_result_during_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.writing |=> !$rose(res_o.valid))
    else $error("result raised during fill");

  // an out of canvas command never returns a pixel value
  a_err_zero_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.range_error |-> res_o.read_color == '0)
    else $error("range error with nonzero read color");

endmodule

FILE: sv/rrf_ram.sv
// ---------------------------------------------------------------------------
// rrf_ram: generic single-port RAM
// One write and one read per cycle at a shared address, read data registered.
// ---------------------------------------------------------------------------
module rrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rrf_front.sv
// ---------------------------------------------------------------------------
// rrf_front: command front end
// Holds the canvas registers, checks the coordinates of each command and
// turns it into a box to write, a pixel to read or a bare result.
// ---------------------------------------------------------------------------
module rrf_front import rrf_pkg::*; #(
  parameter int unsigned MaxDim = DefMaxDim,
  localparam int unsigned ColW  = $clog2(MaxDim),
  localparam int unsigned AddrW = $clog2(MaxDim * MaxDim),
  localparam int unsigned DimW  = $clog2(MaxDim + 1),
  localparam int unsigned CmpW  = (DimW > CoordW) ? DimW : CoordW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rrf_cmd_if.sink          cmd_i,
  rrf_cfg_if.sink          cfg_i,
  input  logic             q_full_i,
  output logic             push_o,
  output rrf_ctl_t         ctl_o,
  output logic [ColW-1:0]  c0_o,
  output logic [ColW-1:0]  c1_o,
  output logic [ColW-1:0]  r0_o,
  output logic [ColW-1:0]  r1_o,
  output logic [AddrW-1:0] addr_o
);

  logic [CoordW-1:0] width_q, width_d;
  logic [CoordW-1:0] height_q, height_d;

  logic [CmpW-1:0] used_cols, used_rows;
  logic [CmpW-1:0] cs, ce, rs, re;
  logic            cs_ok, ce_ok, rs_ok, re_ok;
  logic [CmpW-1:0] sc0, sc1, sr0, sr1;
  logic            box_ok, empty;
  logic [ColW-1:0] r0_idx, c0_idx;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_i.valid) begin
      if (cfg_i.index == REG_CANVAS_WIDTH) begin
        width_d = cfg_i.data[CoordW-1:0];
      end else if (cfg_i.index == REG_CANVAS_HEIGHT) begin
        height_d = cfg_i.data[CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CANVAS_RESET;
      height_q <= CANVAS_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // canvas sizes above the store are taken as the store size
  assign used_cols = (CmpW'(width_q) > CmpW'(MaxDim)) ? CmpW'(MaxDim) : CmpW'(width_q);
  assign used_rows = (CmpW'(height_q) > CmpW'(MaxDim)) ? CmpW'(MaxDim) : CmpW'(height_q);

  assign cs = CmpW'(cmd_i.col_start);
  assign ce = CmpW'(cmd_i.col_end);
  assign rs = CmpW'(cmd_i.row_start);
  assign re = CmpW'(cmd_i.row_end);

  assign cs_ok = (cs != '0) && (cs <= used_cols);
  assign ce_ok = (ce != '0) && (ce <= used_cols);
  assign rs_ok = (rs != '0) && (rs <= used_rows);
  assign re_ok = (re != '0) && (re <= used_rows);

  always_comb begin
    ctl_o.kind  = KIND_NONE;
    ctl_o.err   = 1'b0;
    ctl_o.color = cmd_i.color;
    box_ok      = 1'b0;
    sc0         = cs;
    sc1         = cs;
    sr0         = rs;
    sr1         = rs;
    case (cmd_i.func)
      FUNC_CLEAR: begin
        box_ok      = (used_cols != '0) && (used_rows != '0);
        ctl_o.color = CLEAR_COLOR;
        sc0         = CmpW'(1);
        sc1         = used_cols;
        sr0         = CmpW'(1);
        sr1         = used_rows;
      end
      FUNC_PLOT: begin
        box_ok = cs_ok && rs_ok;
      end
      FUNC_VLINE: begin
        box_ok = cs_ok && rs_ok && re_ok;
        sr1    = re;
      end
      FUNC_HLINE: begin
        box_ok = cs_ok && ce_ok && rs_ok;
        sc1    = ce;
      end
      FUNC_RECT: begin
        box_ok = cs_ok && ce_ok && rs_ok && re_ok;
        sc1    = ce;
        sr1    = re;
      end
      FUNC_READ: begin
        if (cs_ok && rs_ok) begin
          ctl_o.kind = KIND_READ;
        end else begin
          ctl_o.err = 1'b1;
        end
      end
      default: begin
        ctl_o.kind = KIND_NONE;
      end
    endcase
    empty = (sc0 > sc1) || (sr0 > sr1);
    if (cmd_i.func == FUNC_PLOT || cmd_i.func == FUNC_VLINE ||
        cmd_i.func == FUNC_HLINE || cmd_i.func == FUNC_RECT) begin
      ctl_o.err = !box_ok;
    end
    if (box_ok && !empty) begin
      ctl_o.kind = KIND_FILL;
    end
  end

  // 0-based indexes and the store address of the first pixel
  assign c0_idx = ColW'(sc0 - CmpW'(1));
  assign r0_idx = ColW'(sr0 - CmpW'(1));
  assign c0_o   = c0_idx;
  assign c1_o   = ColW'(sc1 - CmpW'(1));
  assign r0_o   = r0_idx;
  assign r1_o   = ColW'(sr1 - CmpW'(1));
  assign addr_o = AddrW'(r0_idx) * AddrW'(MaxDim) + AddrW'(c0_idx);

  assign cmd_i.ready = !q_full_i;
  assign push_o      = cmd_i.valid && !q_full_i;

endmodule

FILE: sv/rrf_queue.sv
// ---------------------------------------------------------------------------
// rrf_queue: short item queue
// Register based FIFO between the front end and the drawing back end.
// ---------------------------------------------------------------------------
module rrf_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned PtrW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: sv/rrf_back.sv
// ---------------------------------------------------------------------------
// rrf_back: drawing back end
// Sweeps each box over the frame store one pixel a cycle, reads single
// pixels and delivers one result item per command through an output register.
// ---------------------------------------------------------------------------
module rrf_back import rrf_pkg::*; #(
  parameter int unsigned MaxDim = DefMaxDim,
  localparam int unsigned ColW  = $clog2(MaxDim),
  localparam int unsigned AddrW = $clog2(MaxDim * MaxDim)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  rrf_ctl_t          ctl_i,
  input  logic [ColW-1:0]   c0_i,
  input  logic [ColW-1:0]   c1_i,
  input  logic [ColW-1:0]   r0_i,
  input  logic [ColW-1:0]   r1_i,
  input  logic [AddrW-1:0]  addr_i,
  output logic              pop_o,
  output rrf_back_st_t      st_o,
  rrf_res_if.source         res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [ColW-1:0]   c0_q, c0_d, c1_q, c1_d, r1_q, r1_d;
  logic [ColW-1:0]   col_q, col_d, row_q, row_d;
  logic [AddrW-1:0]  addr_q, addr_d, row_addr_q, row_addr_d;
  logic [ColorW-1:0] color_q, color_d;
  logic              err_q, err_d, rd_sel_q, rd_sel_d;
  logic              out_valid_q, out_valid_d;
  logic [ColorW-1:0] out_color_q, out_color_d;
  logic              out_err_q, out_err_d;
  logic              slot_free;
  logic              ram_we, ram_re;
  logic [ColorW-1:0] ram_rdata;

  assign slot_free = !out_valid_q || res_o.ready;
  assign pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign ram_we    = (state_q == ST_FILL);
  assign ram_re    = (state_q == ST_READ);

  assign st_o.idle    = (state_q == ST_IDLE);
  assign st_o.writing = ram_we;

  always_comb begin
    state_d     = state_q;
    c0_d        = c0_q;
    c1_d        = c1_q;
    r1_d        = r1_q;
    col_d       = col_q;
    row_d       = row_q;
    addr_d      = addr_q;
    row_addr_d  = row_addr_q;
    color_d     = color_q;
    err_d       = err_q;
    rd_sel_d    = rd_sel_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_color_d = out_color_q;
    out_err_d   = out_err_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          c0_d       = c0_i;
          c1_d       = c1_i;
          r1_d       = r1_i;
          col_d      = c0_i;
          row_d      = r0_i;
          addr_d     = addr_i;
          row_addr_d = addr_i;
          color_d    = ctl_i.color;
          err_d      = ctl_i.err;
          rd_sel_d   = 1'b0;
          case (ctl_i.kind)
            KIND_FILL: state_d = ST_FILL;
            KIND_READ: state_d = ST_READ;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_FILL: begin
        if (col_q == c1_q) begin
          if (row_q == r1_q) begin
            state_d = ST_RESP;
          end else begin
            // step down one row, back to the first column
            row_d      = row_q + ColW'(1);
            col_d      = c0_q;
            row_addr_d = row_addr_q + AddrW'(MaxDim);
            addr_d     = row_addr_q + AddrW'(MaxDim);
          end
        end else begin
          col_d  = col_q + ColW'(1);
          addr_d = addr_q + AddrW'(1);
        end
      end
      ST_READ: begin
        rd_sel_d = 1'b1;
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_color_d = rd_sel_q ? ram_rdata : '0;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c0_q        <= c0_d;
    c1_q        <= c1_d;
    r1_q        <= r1_d;
    col_q       <= col_d;
    row_q       <= row_d;
    addr_q      <= addr_d;
    row_addr_q  <= row_addr_d;
    color_q     <= color_d;
    err_q       <= err_d;
    rd_sel_q    <= rd_sel_d;
    out_color_q <= out_color_d;
    out_err_q   <= out_err_d;
  end

  rrf_ram #(
    .Width (ColorW),
    .Depth (MaxDim * MaxDim)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (addr_q),
    .wdata_i (color_q),
    .rdata_o (ram_rdata)
  );

  assign res_o.valid       = out_valid_q;
  assign res_o.read_color  = out_color_q;
  assign res_o.range_error = out_err_q;

endmodule
